// File: design/sdt_pkg.sv
// Shared types, constants and codes for the seen-device table.
`timescale 1ns / 1ps
package sdt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int ADDR_W            = 48;
  localparam int RSSI_W            = 8;
  localparam int ROUND_W           = 8;
  localparam int AGE_W             = 4;
  localparam int OUT_CNT_W         = 5;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 4'd2;

  localparam logic OP_ADVERT   = 1'b0;
  localparam logic OP_SCAN_END = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [ADDR_W-1:0]        device_address;
    logic signed [RSSI_W-1:0] rssi;
    logic                     qualifies;
  } in_item_t;

  typedef struct packed {
    logic signed [RSSI_W-1:0] strongest_rssi;
    logic [OUT_CNT_W-1:0]     device_count;
    logic                     dropped;
    logic [OUT_CNT_W-1:0]     removed_count;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [RSSI_W-1:0]  strength;
    logic [ROUND_W-1:0] last_round;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Item and accumulator context handed to the entry unit
  typedef struct packed {
    logic                     is_scan;
    logic                     qual;
    logic [ADDR_W-1:0]        addr;
    logic [RSSI_W-1:0]        rssi;
    logic [ROUND_W-1:0]       round;
    logic [AGE_W-1:0]         age_limit;
    logic                     found;
    logic                     any;
    logic signed [RSSI_W-1:0] best;
  } unit_ctx_t;

  // Verdict of the entry unit for one entry
  typedef struct packed {
    logic                     hit;
    logic                     take_free;
    logic                     expire;
    logic                     live;
    logic                     any;
    logic signed [RSSI_W-1:0] best;
  } unit_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

// File: design/sdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sdt_entry_unit.sv
// Shared compare unit: address match, age test and strongest-signal update.
`timescale 1ns / 1ps
module sdt_entry_unit (
  input  sdt_pkg::entry_t    ent,
  input  logic               ent_valid,
  input  sdt_pkg::unit_ctx_t ctx,
  output sdt_pkg::unit_res_t res
);
  import sdt_pkg::*;

  logic [ROUND_W-1:0]       age;
  logic signed [RSSI_W-1:0] str;
  logic                     advert_q;
  logic                     better;

  always_comb begin
    advert_q = (ctx.is_scan == OP_ADVERT) && ctx.qual;
    // Match the first live entry with the advert's address
    res.hit       = advert_q && ent_valid && !ctx.found && (ent.address == ctx.addr);
    res.take_free = advert_q && !ent_valid;
    // Modular age against the limit
    age        = ctx.round - ent.last_round;
    res.expire = (ctx.is_scan == OP_SCAN_END) && ent_valid
                 && (age > {{(ROUND_W-AGE_W){1'b0}}, ctx.age_limit});
    res.live   = ent_valid && !res.expire;
    // Fold this entry's strength into the running maximum
    str      = res.hit ? $signed(ctx.rssi) : $signed(ent.strength);
    better   = !ctx.any || (str > ctx.best);
    res.best = (res.live && better) ? str : ctx.best;
    res.any  = ctx.any || res.live;
  end

endmodule

// File: design/seen_device_table_with_aging_core.sv
// Top level: sequencer walking the device table through the shared entry unit.
//
// Usage:
//   Input items (adverts and scan ends) arrive on in_valid / in_item and are
//   taken when in_stall is low. Each item walks every table slot once, one
//   slot per cycle, through a single compare unit fed by the entry RAM's
//   registered read port; a final step inserts a new device if needed,
//   advances the round on a scan end and loads the result register.
//   A new item is not taken until the previous one has loaded its result.
//   in_stall is high from acceptance until the result is loaded.
//   The result waits in an output register; the next item can be taken
//   while it waits, but its walk stops before the final step as long as
//   out_stall holds the previous result.
//   The age limit is written on cfg_valid / cfg_data while no item is in
//   flight; cfg_ready is high when the block is idle.
//   Reset (rst_n low, synchronous) empties the table, sets the round to 0,
//   the age limit to 2 and drops any pending result. The entry RAM itself
//   is not cleared; only slots marked valid are ever used.
`timescale 1ns / 1ps
module seen_device_table_with_aging_core #(
  parameter int TABLE_ENTRIES = sdt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sdt_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sdt_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sdt_pkg::AGE_W-1:0]   cfg_data
);
  import sdt_pkg::*;

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW   = (CNTW > OUT_CNT_W) ? CNTW : OUT_CNT_W;

  state_t                   state_r, state_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic                     proc_r, proc_nxt;
  logic [AW-1:0]            pidx_r, pidx_nxt;
  in_item_t                 item_r, item_nxt;
  logic [ROUND_W-1:0]       round_r, round_nxt;
  logic [AGE_W-1:0]         age_limit_r, age_limit_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     found_r, found_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [AW-1:0]            free_idx_r, free_idx_nxt;
  logic                     any_r, any_nxt;
  logic signed [RSSI_W-1:0] best_r, best_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            removed_r, removed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic                     in_take;
  logic                     walk_done;
  logic                     fin_go;
  logic                     issue;
  logic                     insert_ok;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  entry_t                   ram_wdata;
  entry_t                   ram_rdata;
  entry_t                   new_ent;
  entry_t                   unit_ent;
  logic                     unit_valid;
  unit_ctx_t                ctx;
  unit_res_t                res;
  logic [CW-1:0]            fin_count;

  assign in_take   = in_valid && !in_stall;
  assign walk_done = (cnt_r == CNTW'(TABLE_ENTRIES));
  assign fin_go    = (state_r == ST_FINISH) && !(out_valid_r && out_stall);
  assign issue     = (state_r == ST_WALK) && !walk_done;
  assign insert_ok = (item_r.opcode == OP_ADVERT) && item_r.qualifies
                     && !found_r && free_found_r;

  assign new_ent.address    = item_r.device_address;
  assign new_ent.strength   = item_r.rssi;
  assign new_ent.last_round = round_r;

  // Entry storage: address, strength and round per slot
  sdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Feed the shared unit: a stored slot during the walk, the new device at the end
  always_comb begin
    unit_ent       = (state_r == ST_FINISH) ? new_ent : ram_rdata;
    unit_valid     = (state_r == ST_FINISH) ? insert_ok : valid_r[pidx_r];
    ctx.is_scan    = item_r.opcode;
    ctx.qual       = item_r.qualifies;
    ctx.addr       = item_r.device_address;
    ctx.rssi       = item_r.rssi;
    ctx.round      = round_r;
    ctx.age_limit  = age_limit_r;
    ctx.found      = (state_r == ST_FINISH) ? 1'b0 : found_r;
    ctx.any        = any_r;
    ctx.best       = best_r;
  end

  sdt_entry_unit u_unit (
    .ent       (unit_ent),
    .ent_valid (unit_valid),
    .ctx       (ctx),
    .res       (res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    out_item  = out_r;
  end

  // Datapath: walk accumulators, table updates and result
  always_comb begin
    cnt_nxt        = cnt_r;
    proc_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    item_nxt       = item_r;
    round_nxt      = round_r;
    age_limit_nxt  = age_limit_r;
    valid_nxt      = valid_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    any_nxt        = any_r;
    best_nxt       = best_r;
    count_nxt      = count_r;
    removed_nxt    = removed_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = pidx_r;
    ram_wdata      = new_ent;
    fin_count      = count_r + CW'(res.live);

    if (cfg_valid && cfg_ready) begin
      age_limit_nxt = cfg_data;
    end

    // Capture the item and clear the accumulators
    if (in_take) begin
      item_nxt       = in_item;
      cnt_nxt        = '0;
      found_nxt      = 1'b0;
      free_found_nxt = 1'b0;
      any_nxt        = 1'b0;
      best_nxt       = '0;
      count_nxt      = '0;
      removed_nxt    = '0;
    end

    // Issue the next slot read
    if (issue) begin
      cnt_nxt  = cnt_r + CNTW'(1);
      proc_nxt = 1'b1;
      pidx_nxt = cnt_r[AW-1:0];
    end

    // Process the slot whose data has just come back
    if ((state_r == ST_WALK) && proc_r) begin
      if (res.hit) begin
        found_nxt = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = pidx_r;
      end
      if (res.take_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = pidx_r;
      end
      if (res.expire) begin
        valid_nxt[pidx_r] = 1'b0;
        removed_nxt       = removed_r + CW'(1);
      end
      if (res.live) begin
        count_nxt = count_r + CW'(1);
      end
      any_nxt  = res.any;
      best_nxt = res.best;
    end

    // Insert a new device if needed, advance the round on a scan end and load the result
    if (fin_go) begin
      if (insert_ok) begin
        valid_nxt[free_idx_r] = 1'b1;
        ram_we                = 1'b1;
        ram_waddr             = free_idx_r;
      end
      if (item_r.opcode == OP_SCAN_END) begin
        round_nxt = round_r + ROUND_W'(1);
      end
      out_valid_nxt          = 1'b1;
      out_nxt.strongest_rssi = res.any ? res.best : '0;
      out_nxt.device_count   = fin_count[OUT_CNT_W-1:0];
      out_nxt.dropped        = (item_r.opcode == OP_ADVERT) && item_r.qualifies
                               && !found_r && !free_found_r;
      out_nxt.removed_count  = removed_r[OUT_CNT_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      proc_r      <= 1'b0;
      round_r     <= '0;
      age_limit_r <= AGE_LIMIT_RST;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_r      <= proc_nxt;
      round_r     <= round_nxt;
      age_limit_r <= age_limit_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    item_r       <= item_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    any_r        <= any_nxt;
    best_r       <= best_nxt;
    count_r      <= count_nxt;
    removed_r    <= removed_nxt;
    out_r        <= out_nxt;
  end

endmodule

// File: design/sdt_checker.sv
// Port-level checks for the seen-device table, bound to the top level.
`timescale 1ns / 1ps
module sdt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sdt_pkg::out_item_t out_item
);
  import sdt_pkg::*;

  // Reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still offered after reset");

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second item back to back");

  // A dropped advert never reports aged-out entries
  a_drop_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.dropped |-> out_item.removed_count == '0)
    else $error("dropped advert reports removed entries");

endmodule

bind seen_device_table_with_aging_core sdt_checker u_sdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
